@@ design/bfss_pkg.sv @@
package bfss_pkg;

  localparam int unsigned WEIGHT_REGS = 4;
  localparam int unsigned WEIGHT_W    = 8;
  localparam int unsigned BC_W        = 13;
  localparam int unsigned ACC_W       = 32;
  localparam int unsigned ACC_CNT_W   = 5;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ROW_W       = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT = 3'd4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_0_RST = 8'd31;
  localparam logic [WEIGHT_W-1:0] WEIGHT_1_RST = 8'd37;
  localparam logic [WEIGHT_W-1:0] WEIGHT_2_RST = 8'd41;
  localparam logic [WEIGHT_W-1:0] WEIGHT_3_RST = 8'd43;
  localparam logic [BC_W-1:0]     BIT_COUNT_RST = 13'd4096;

  localparam logic      CMD_INSERT = 1'b0;
  localparam logic      CMD_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_UPD,
    ST_OUT
  } state_t;

endpackage

@@ design/bloom_filter_string_set.sv @@
// Bytes: one word per cycle while a string is open; a nonzero one updates every hash lane.
// String end: after the last byte, input is held off while the bit-serial remainder unit
//   reduces all lanes in parallel, then a read-modify-write of the bit store runs one hash
//   at a time; after a query, input also waits until the result register is free.
// Query result is held until taken.
// Reset (rst_n low, synchronous): control and config registers go to defaults; a clearing
//   pass zeroes all ceil(MAX_BITS/8) store rows; input is held off, config is still taken.
module bloom_filter_string_set #(
  parameter int unsigned NUM_HASHES = 4,
  parameter int unsigned MAX_BITS   = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bfss_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] char_byte
  input  logic                               in_tuser,   // [0] cmd
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bfss_pkg::OUT_DATA_W-1:0]    out_tdata,  // [0] is_member, [7:1] zero
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bfss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bfss_pkg::*;

  localparam int unsigned ROWS      = (MAX_BITS + ROW_W - 1) / ROW_W;
  localparam int unsigned ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned HK_W      = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
  localparam int unsigned MAX_CLAMP = (MAX_BITS > 8191) ? 8191 : MAX_BITS;
  localparam logic [BC_W-1:0] MAX_M = BC_W'(MAX_CLAMP);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
  localparam logic [HK_W-1:0]   LAST_K   = HK_W'(NUM_HASHES - 1);

  state_t state_r, state_nxt;

  logic [WEIGHT_W-1:0]  weight_r   [WEIGHT_REGS];
  logic [WEIGHT_W-1:0]  weight_nxt [WEIGHT_REGS];
  logic [BC_W-1:0]      bit_count_r, bit_count_nxt;
  logic [ACC_W-1:0]     acc_r      [NUM_HASHES];
  logic [ACC_W-1:0]     acc_nxt    [NUM_HASHES];
  logic [BC_W-1:0]      rem_r      [NUM_HASHES];
  logic [BC_W-1:0]      rem_nxt    [NUM_HASHES];
  logic [ACC_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [HK_W-1:0]      k_r, k_nxt;
  logic [ROW_AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                 cmd_r, cmd_nxt;
  logic                 all_set_r, all_set_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 is_member_r, is_member_nxt;

  logic [ROW_W-1:0]     bit_mem [ROWS];
  logic [ROW_W-1:0]     mem_q_r;
  logic                 mem_we;
  logic [ROW_AW-1:0]    mem_waddr;
  logic [ROW_W-1:0]     mem_wdata;
  logic [ROW_AW-1:0]    rd_addr;
  logic [BC_W-1:0]      mod_val;
  logic [BC_W-1:0]      cur_rem;
  logic [2:0]           cur_bit;
  logic [ROW_W-1:0]     bit_mask;
  logic [BC_W:0]        trial [NUM_HASHES];
  logic                 in_acc;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, is_member_r};
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;

  // zero acts as one, anything past the store size acts as the store size
  always_comb begin
    if (bit_count_r == '0) begin
      mod_val = BC_W'(1);
    end else if (bit_count_r > MAX_M) begin
      mod_val = MAX_M;
    end else begin
      mod_val = bit_count_r;
    end
  end

  assign cur_rem  = rem_r[k_r];
  assign cur_bit  = cur_rem[2:0];
  assign rd_addr  = ROW_AW'(cur_rem >> 3);
  assign bit_mask = ROW_W'(1) << cur_bit;

  // one remainder bit per cycle for every lane: shift in the next accumulator MSB
  always_comb begin
    for (int i = 0; i < NUM_HASHES; i++) begin
      trial[i] = {rem_r[i], acc_r[i][ACC_W-1]};
    end
  end

  always_comb begin
    state_nxt      = state_r;
    weight_nxt     = weight_r;
    bit_count_nxt  = bit_count_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    k_nxt          = k_r;
    clr_cnt_nxt    = clr_cnt_r;
    cmd_nxt        = cmd_r;
    all_set_nxt    = all_set_r;
    is_member_nxt  = is_member_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mem_we         = 1'b0;
    mem_waddr      = rd_addr;
    mem_wdata      = mem_q_r | bit_mask;

    if (cfg_valid) begin
      case (cfg_index)
        REG_WEIGHT_0:  weight_nxt[0] = cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_1:  weight_nxt[1] = cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_2:  weight_nxt[2] = cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_3:  weight_nxt[3] = cfg_data[WEIGHT_W-1:0];
        REG_BIT_COUNT: bit_count_nxt = cfg_data[BC_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + ROW_AW'(1);
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tdata != '0) begin
            for (int i = 0; i < NUM_HASHES; i++) begin
              acc_nxt[i] = ACC_W'(acc_r[i] * ACC_W'(weight_r[i])) + ACC_W'(in_tdata);
            end
          end
          if (in_tlast) begin
            cmd_nxt     = in_tuser;
            all_set_nxt = 1'b1;
            div_cnt_nxt = '0;
            for (int i = 0; i < NUM_HASHES; i++) begin
              rem_nxt[i] = '0;
            end
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // shifting out the accumulators also leaves them at zero for the next string
        for (int i = 0; i < NUM_HASHES; i++) begin
          acc_nxt[i] = acc_r[i] << 1;
          if (trial[i] >= {1'b0, mod_val}) begin
            rem_nxt[i] = BC_W'(trial[i] - {1'b0, mod_val});
          end else begin
            rem_nxt[i] = BC_W'(trial[i]);
          end
        end
        div_cnt_nxt = div_cnt_r + ACC_CNT_W'(1);
        if (div_cnt_r == ACC_CNT_W'(ACC_W - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (cmd_r == CMD_INSERT) begin
          mem_we = 1'b1;
        end else begin
          all_set_nxt = all_set_r && mem_q_r[cur_bit];
        end
        if (k_r == LAST_K) begin
          state_nxt = (cmd_r == CMD_QUERY) ? ST_OUT : ST_IDLE;
        end else begin
          k_nxt     = k_r + HK_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          is_member_nxt  = all_set_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      weight_r[0]  <= WEIGHT_0_RST;
      weight_r[1]  <= WEIGHT_1_RST;
      weight_r[2]  <= WEIGHT_2_RST;
      weight_r[3]  <= WEIGHT_3_RST;
      bit_count_r  <= BIT_COUNT_RST;
      for (int i = 0; i < NUM_HASHES; i++) begin
        acc_r[i] <= '0;
      end
      div_cnt_r    <= '0;
      k_r          <= '0;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      weight_r     <= weight_nxt;
      bit_count_r  <= bit_count_nxt;
      acc_r        <= acc_nxt;
      div_cnt_r    <= div_cnt_nxt;
      k_r          <= k_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    cmd_r       <= cmd_nxt;
    all_set_r   <= all_set_nxt;
    is_member_r <= is_member_nxt;
  end

  // bit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bit_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= bit_mem[rd_addr];
  end

endmodule

@@ design/bfss_checker.sv @@
module bfss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bfss_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // the clearing pass keeps input off right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during bit store clear");

  // the end of a string starts the hash reduction, which takes no more words
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("word taken while a string is being reduced");

  // a new result comes only out of the reduction of a query
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while bytes were being taken");

endmodule

bind bloom_filter_string_set bfss_checker u_bfss_checker (.*);
